// File: rtl/core/rrqs_pkg.sv
// Shared types, codes and helpers of the round-robin quantum scheduler.
// Depends on nothing; imported by round_robin_quantum_scheduler.
package rrqs_pkg;

  localparam int SLOT_BITS = 4;
  localparam int NUM_SLOTS = 2 ** SLOT_BITS;
  localparam int PRIO_BITS = 8;
  localparam int QUANT_BITS = 8;
  localparam int CPU_BITS = 3;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 3;

  localparam logic [SLOT_BITS:0] SLOT_COUNT = (SLOT_BITS + 1)'(NUM_SLOTS);
  localparam logic [SLOT_BITS-1:0] IDLE_SLOT = '0;

  // Task run states
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_WAITING = 2'd2;
  localparam logic [1:0] ST_ZOMBIE = 2'd3;

  // Request actions
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CPU = 1'b1;

  typedef enum logic [2:0] {
    OC_DISABLED = 3'd0,
    OC_KEPT = 3'd1,
    OC_SWITCHED = 3'd2,
    OC_REFRESHED = 3'd3,
    OC_NONE = 3'd4,
    OC_WRITTEN = 3'd5
  } outcome_t;

  typedef struct packed {
    logic action;
    logic [SLOT_BITS-1:0] slot_index;
    logic [1:0] run_state;
    logic [PRIO_BITS-1:0] task_priority;
    logic [CPU_BITS-1:0] home_cpu;
  } req_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0] running_slot;
    outcome_t outcome;
    logic [QUANT_BITS-1:0] quantum_left;
  } res_t;

  // One task slot as kept in the slot table
  typedef struct packed {
    logic [1:0] run_state;
    logic [PRIO_BITS-1:0] prio;
    logic [QUANT_BITS-1:0] quantum;
    logic [CPU_BITS-1:0] cpu;
  } slot_t;

  // Quantum loaded on selection: the priority, or one when it is zero
  function automatic logic [QUANT_BITS-1:0] fresh_quantum(input logic [PRIO_BITS-1:0] prio);
    logic [QUANT_BITS-1:0] q;
    q = QUANT_BITS'(prio);
    if (prio == '0) begin
      q = QUANT_BITS'(1);
    end
    return q;
  endfunction

endpackage

// File: rtl/core/round_robin_quantum_scheduler.sv
// Top level of the round-robin quantum scheduler: slot table, sequencer, config.
// Depends on rrqs_pkg.

// A request is taken when start is high and busy is low. A slot write or a tick
// while disabled gives its result in the next cycle. An enabled tick reads the
// running slot first (the result is given from S_CUR when the task is kept), then scans
// the other slots through the single read port of the slot table, one slot per
// cycle, until it finds a task to switch to or falls back. Each result is marked by
// done, high for a single cycle; the
// receiver cannot stall it, and done coincides with busy going low. The slot
// table comes out of reset empty by per-slot valid bits, so no clearing pass is needed.
module round_robin_quantum_scheduler import rrqs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic done,
  output res_t result,
  input  logic cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CUR  = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state;

  logic sched_enable;
  logic [CPU_BITS-1:0] local_cpu;

  logic [SLOT_BITS-1:0] cur;
  logic [QUANT_BITS-1:0] cur_q;
  logic [SLOT_BITS:0] k;
  slot_t cur_ent;
  slot_t idle_ent;

  // Slot table and its read port
  slot_t mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid;
  slot_t rd_data;
  logic rd_vld;
  logic rd_live;
  logic [SLOT_BITS-1:0] rd_slot;

  logic mem_we;
  logic [SLOT_BITS-1:0] mem_waddr;
  slot_t mem_wdata;
  logic rd_en;
  logic [SLOT_BITS-1:0] rd_addr;

  logic accept;
  logic tick_go;
  slot_t ent;
  logic [QUANT_BITS-1:0] q_dec;
  logic kept;
  logic hit;
  logic fallback;
  logic cur_run;
  logic idle_run;

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign tick_go = accept && (request.action == ACT_TICK) && sched_enable;

  // Decode the read data and the tick decisions
  always_comb begin
    ent = rd_vld ? rd_data : '0;
    q_dec = (ent.quantum != '0) ? ent.quantum - QUANT_BITS'(1) : '0;
    kept = (ent.run_state == ST_RUNNING) && (q_dec != '0);
    hit = rd_live && (rd_slot != IDLE_SLOT) && (ent.run_state == ST_RUNNING) &&
          (ent.cpu == local_cpu);
    fallback = !rd_live;
    cur_run = (cur_ent.run_state == ST_RUNNING);
    idle_run = (idle_ent.run_state == ST_RUNNING);
  end

  // Drive the table ports from the sequencer
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = cur;
    mem_wdata = ent;
    rd_en = 1'b0;
    rd_addr = cur + k[SLOT_BITS-1:0];
    case (state)
      S_IDLE: begin
        rd_addr = cur;
        rd_en = tick_go;
        if (accept && (request.action == ACT_WRITE)) begin
          mem_we = 1'b1;
          mem_waddr = request.slot_index;
          mem_wdata.run_state = request.run_state;
          mem_wdata.prio = request.task_priority;
          mem_wdata.cpu = request.home_cpu;
          mem_wdata.quantum = QUANT_BITS'(1);
        end
      end
      S_CUR: begin
        mem_we = 1'b1;
        mem_waddr = cur;
        mem_wdata.quantum = q_dec;
        rd_en = !kept;
      end
      S_SCAN: begin
        rd_en = !hit && (k < SLOT_COUNT);
        if (hit) begin
          mem_we = 1'b1;
          mem_waddr = rd_slot;
          mem_wdata.quantum = fresh_quantum(ent.prio);
        end else if (fallback) begin
          if (cur_run) begin
            mem_we = 1'b1;
            mem_waddr = cur;
            mem_wdata = cur_ent;
            mem_wdata.quantum = fresh_quantum(cur_ent.prio);
          end else if (idle_run) begin
            mem_we = 1'b1;
            mem_waddr = IDLE_SLOT;
            mem_wdata = idle_ent;
            mem_wdata.quantum = fresh_quantum(idle_ent.prio);
          end
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Hold the slot table; registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
    rd_slot <= rd_addr;
  end

  // Track written slots and the read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_vld <= 1'b0;
      rd_live <= 1'b0;
    end else begin
      if (mem_we) begin
        valid[mem_waddr] <= 1'b1;
      end
      rd_vld <= valid[rd_addr];
      rd_live <= rd_en;
    end
  end

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sched_enable <= 1'b0;
      local_cpu <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE: sched_enable <= cfg_data[0];
        CFG_CPU: local_cpu <= cfg_data[CPU_BITS-1:0];
        default: sched_enable <= sched_enable;
      endcase
    end
  end

  // Advance the sequencer and emit results
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      cur <= IDLE_SLOT;
      cur_q <= '0;
      k <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (request.action == ACT_WRITE) begin
              done <= 1'b1;
              result.running_slot <= cur;
              result.outcome <= OC_WRITTEN;
              if (request.slot_index == cur) begin
                cur_q <= QUANT_BITS'(1);
                result.quantum_left <= QUANT_BITS'(1);
              end else begin
                result.quantum_left <= cur_q;
              end
            end else if (!sched_enable) begin
              done <= 1'b1;
              result.running_slot <= cur;
              result.outcome <= OC_DISABLED;
              result.quantum_left <= cur_q;
            end else begin
              k <= (SLOT_BITS + 1)'(1);
              state <= S_CUR;
            end
          end
        end
        S_CUR: begin
          cur_q <= q_dec;
          cur_ent <= '{run_state: ent.run_state, prio: ent.prio, quantum: q_dec, cpu: ent.cpu};
          if (cur == IDLE_SLOT) begin
            idle_ent <= '{run_state: ent.run_state, prio: ent.prio, quantum: q_dec,
                          cpu: ent.cpu};
          end
          if (kept) begin
            done <= 1'b1;
            result.running_slot <= cur;
            result.outcome <= OC_KEPT;
            result.quantum_left <= q_dec;
            state <= S_IDLE;
          end else begin
            k <= k + (SLOT_BITS + 1)'(1);
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_live && (rd_slot == IDLE_SLOT)) begin
            idle_ent <= ent;
          end
          if (k < SLOT_COUNT) begin
            k <= k + (SLOT_BITS + 1)'(1);
          end
          if (hit) begin
            done <= 1'b1;
            cur <= rd_slot;
            cur_q <= fresh_quantum(ent.prio);
            result.running_slot <= rd_slot;
            result.outcome <= OC_SWITCHED;
            result.quantum_left <= fresh_quantum(ent.prio);
            state <= S_IDLE;
          end else if (fallback) begin
            done <= 1'b1;
            state <= S_IDLE;
            if (cur_run) begin
              cur_q <= fresh_quantum(cur_ent.prio);
              result.running_slot <= cur;
              result.outcome <= OC_REFRESHED;
              result.quantum_left <= fresh_quantum(cur_ent.prio);
            end else if (idle_run) begin
              cur <= IDLE_SLOT;
              cur_q <= fresh_quantum(idle_ent.prio);
              result.running_slot <= IDLE_SLOT;
              result.outcome <= OC_SWITCHED;
              result.quantum_left <= fresh_quantum(idle_ent.prio);
            end else begin
              result.running_slot <= cur;
              result.outcome <= OC_NONE;
              result.quantum_left <= cur_q;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result always ends the request, so the block is free when it shows
  a_done_free: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobed while still busy");

  // Slot writes and disabled ticks finish in the next cycle
  a_fast_done: assert property (@(posedge clk) disable iff (rst)
    (accept && ((request.action == ACT_WRITE) || !sched_enable)) |=> (done && !busy))
    else $error("single-cycle request did not complete");

  // The read pipeline runs only while a tick is being worked on
  a_read_owned: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> busy)
    else $error("slot table read issued outside a tick");

  // The scan pointer never runs past the table
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (k <= SLOT_COUNT))
    else $error("scan pointer out of range");

endmodule
